[hw/rtl/rtp_pkg.sv]
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared types, constants and elaboration-time helpers for the rectangular to
// polar converter.
// ----------------------------------------------------------------------------
package rtp_pkg;

  // Fraction bits added to the coordinates on entry
  localparam int GUARD_BITS = 16;
  // Angle accumulator width: Q30 radians, headroom for about +-8 rad
  localparam int ZW         = 34;
  // Inverse gain width (value below 2^30 for any supported iteration count)
  localparam int KW         = 31;
  // Result field width
  localparam int OUT_W      = 16;
  // Magnitude scaling: Q16 coordinate times Q30 gain
  localparam int MAG_SHIFT  = 46;
  // Phase scaling: Q30 down to Q13
  localparam int PH_SHIFT   = 17;

  localparam int unsigned MAG_MAX  = 65535;
  localparam int          PHASE_PI = 25736;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  // atan(2^-i) in radians, Q30, rounded to nearest
  localparam logic [29:0] ATAN_TAB [0:31] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
    30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
    30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
    30'd262144,    30'd131072,    30'd65536,     30'd32768,
    30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128,
    30'd64,        30'd32,        30'd16,        30'd8,
    30'd4,         30'd2,         30'd1,         30'd0
  };

  // Control tag that travels alongside each item in the pipeline
  typedef struct packed {
    logic valid;
    logic origin;
  } rtp_tag_t;

  // Square root (Q30) of the CORDIC gain squared, prod(1 + 2^-2i) in Q60.
  // Used only at elaboration.
  function automatic logic [63:0] gain_sqrt(input int n);
    logic [63:0] p;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    p = 64'd1 << 60;
    for (int i = 0; i < 32; i++) begin
      if (i < n) begin
        p = p + (p >> (2 * i));
      end
    end
    // Bitwise integer square root, two bits of radicand a step
    v = p;
    r = '0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

endpackage

[hw/rtl/rtp_in_if.sv]
// ----------------------------------------------------------------------------
// rtp_in_if
// Valid/ready channel carrying one Cartesian point per item.
// ----------------------------------------------------------------------------
interface rtp_in_if #(
  parameter int DATA_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] x_coord;
  logic signed [DATA_WIDTH-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

[hw/rtl/rtp_out_if.sv]
// ----------------------------------------------------------------------------
// rtp_out_if
// Valid/ready channel carrying one polar result (magnitude, phase) per item.
// ----------------------------------------------------------------------------
interface rtp_out_if import rtp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic        [OUT_W-1:0] magnitude;
  logic signed [OUT_W-1:0] phase;

  modport source (output valid, output magnitude, output phase, input ready);
  modport sink   (input valid, input magnitude, input phase, output ready);
endinterface

[hw/rtl/rect_to_polar_converter_core.sv]
// ----------------------------------------------------------------------------
// rect_to_polar_converter_core
// Pipelined CORDIC (vectoring mode) converting (x, y) to magnitude and phase.
// ----------------------------------------------------------------------------
// Accepts one point per clock while the output is not back-pressured and
// returns one result per point, in order. The stages are one entry stage
// for the quadrant pre-rotation, one registered stage per CORDIC
// micro-rotation, and two stages for the gain-correction multiply (split
// into two partial products) and rounding. Every stage holds its item while
// the stage after it is full, so back-pressure on the output stops the
// pipeline without loss and empty slots are filled as items arrive. Magnitude
// is sqrt(x^2 + y^2) rounded to nearest; phase is atan2(y, x) in Q13 radians,
// clamped to +-25736. The origin yields zero for both. The input interface
// must be instantiated with the same DATA_WIDTH as this block.
// ----------------------------------------------------------------------------
module rect_to_polar_converter_core import rtp_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int ITERATIONS = 16
) (
  input  logic       clk,
  input  logic       rst,
  rtp_in_if.sink     in_ch,
  rtp_out_if.source  out_ch
);

  localparam int XW = DATA_WIDTH + GUARD_BITS + 2;

  // Inverse CORDIC gain, Q30, rounded to nearest
  localparam logic [63:0] GainSqrt = gain_sqrt(ITERATIONS);
  localparam logic [63:0] InvGain  = ((64'd1 << 60) + GainSqrt / 2) / GainSqrt;

  // Pipeline taps: index i is the output of stage i (0 = entry stage)
  rtp_tag_t             tag_p [0:ITERATIONS];
  logic signed [XW-1:0] x_p   [0:ITERATIONS];
  logic signed [XW-1:0] y_p   [0:ITERATIONS];
  logic signed [ZW-1:0] z_p   [0:ITERATIONS];
  logic                 rdy_p [0:ITERATIONS];

  rtp_prerot #(
    .DATA_WIDTH (DATA_WIDTH),
    .XW         (XW)
  ) u_prerot (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .ready_dn (rdy_p[0]),
    .tag      (tag_p[0]),
    .x        (x_p[0]),
    .y        (y_p[0]),
    .z        (z_p[0])
  );

  // One micro-rotation per stage
  for (genvar i = 1; i <= ITERATIONS; i++) begin : g_stage
    rtp_cordic_stage #(
      .XW  (XW),
      .IDX (i - 1)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .tag_in   (tag_p[i-1]),
      .ready_up (rdy_p[i-1]),
      .x_in     (x_p[i-1]),
      .y_in     (y_p[i-1]),
      .z_in     (z_p[i-1]),
      .ready_dn (rdy_p[i]),
      .tag      (tag_p[i]),
      .x        (x_p[i]),
      .y        (y_p[i]),
      .z        (z_p[i])
    );
  end

  rtp_scale #(
    .XW       (XW),
    .INV_GAIN (InvGain[KW-1:0])
  ) u_scale (
    .clk      (clk),
    .rst      (rst),
    .tag_in   (tag_p[ITERATIONS]),
    .ready_up (rdy_p[ITERATIONS]),
    .x_in     (x_p[ITERATIONS]),
    .z_in     (z_p[ITERATIONS]),
    .out_ch   (out_ch)
  );

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("output valid after reset");

  // An empty output stage lets the whole ready chain open
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output stage");

  // Phase stays within +-pi
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.phase <= OUT_W'(PHASE_PI)) &&
                     (out_ch.phase >= -OUT_W'(PHASE_PI)))
    else $error("phase out of range");

  // Zero magnitude only comes from the origin, whose phase is zero
  a_origin_phase: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.magnitude == '0)) |-> (out_ch.phase == '0))
    else $error("nonzero phase with zero magnitude");

endmodule

[hw/rtl/rtp_prerot.sv]
// ----------------------------------------------------------------------------
// rtp_prerot
// Entry stage: widens the coordinates, rotates left-half points by +-pi/2
// into the right half plane and flags the origin.
// ----------------------------------------------------------------------------
module rtp_prerot import rtp_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int XW         = DATA_WIDTH + GUARD_BITS + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  rtp_in_if.sink               in_ch,
  input  logic                 ready_dn,
  output rtp_tag_t             tag,
  output logic signed [XW-1:0] x,
  output logic signed [XW-1:0] y,
  output logic signed [ZW-1:0] z
);

  logic                 valid;
  logic                 origin;
  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] y_ext;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic signed [ZW-1:0] z_next;

  assign in_ch.ready = !valid || ready_dn;
  assign tag         = '{valid: valid, origin: origin};

  // Sign-extend and append the guard fraction bits
  assign x_ext = {{(XW-DATA_WIDTH-GUARD_BITS){in_ch.x_coord[DATA_WIDTH-1]}},
                  in_ch.x_coord, {GUARD_BITS{1'b0}}};
  assign y_ext = {{(XW-DATA_WIDTH-GUARD_BITS){in_ch.y_coord[DATA_WIDTH-1]}},
                  in_ch.y_coord, {GUARD_BITS{1'b0}}};

  // Quadrant pre-rotation; the negative x axis goes to +pi/2
  always_comb begin
    x_next = x_ext;
    y_next = y_ext;
    z_next = '0;
    if (x_ext < 0) begin
      if (y_ext >= 0) begin
        x_next = y_ext;
        y_next = -x_ext;
        z_next = HALF_PI_Q30;
      end else begin
        x_next = -y_ext;
        y_next = x_ext;
        z_next = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ch.ready) begin
      valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      x      <= x_next;
      y      <= y_next;
      z      <= z_next;
      origin <= (x_ext == '0) && (y_ext == '0);
    end
  end

endmodule

[hw/rtl/rtp_cordic_stage.sv]
// ----------------------------------------------------------------------------
// rtp_cordic_stage
// One registered vectoring micro-rotation: drives y toward zero and
// accumulates the matching arctangent.
// ----------------------------------------------------------------------------
module rtp_cordic_stage import rtp_pkg::*; #(
  parameter int XW  = 34,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rtp_tag_t             tag_in,
  output logic                 ready_up,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  logic                 ready_dn,
  output rtp_tag_t             tag,
  output logic signed [XW-1:0] x,
  output logic signed [XW-1:0] y,
  output logic signed [ZW-1:0] z
);

  localparam logic signed [ZW-1:0] ANGLE = ZW'(ATAN_TAB[IDX]);

  logic                 valid;
  logic                 origin;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic signed [ZW-1:0] z_next;

  assign ready_up = !valid || ready_dn;
  assign tag      = '{valid: valid, origin: origin};

  // Floor shifts, then rotate toward the x axis
  assign dx = y_in >>> IDX;
  assign dy = x_in >>> IDX;

  always_comb begin
    if (y_in < 0) begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      z_next = z_in - ANGLE;
    end else begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      z_next = z_in + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= tag_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && tag_in.valid) begin
      x      <= x_next;
      y      <= y_next;
      z      <= z_next;
      origin <= tag_in.origin;
    end
  end

endmodule

[hw/rtl/rtp_scale.sv]
// ----------------------------------------------------------------------------
// rtp_scale
// Two-stage back end: gain correction of the final x as two partial
// products, rounding and saturation of the magnitude, rounding and clamping
// of the phase. Drives the output channel.
// ----------------------------------------------------------------------------
module rtp_scale import rtp_pkg::*; #(
  parameter int             XW       = 34,
  parameter logic [KW-1:0]  INV_GAIN = '0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rtp_tag_t             tag_in,
  output logic                 ready_up,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [ZW-1:0] z_in,
  rtp_out_if.source            out_ch
);

  localparam int XFW  = XW - 1;
  localparam int LO_W = XW / 2;
  localparam int HI_W = XFW - LO_W;
  localparam int SW   = (XFW + KW + 1 > MAG_SHIFT + OUT_W + 1) ?
                        (XFW + KW + 1) : (MAG_SHIFT + OUT_W + 1);
  localparam int MW   = SW - MAG_SHIFT;

  localparam logic signed [ZW-1:0] PI_Z      = ZW'(PHASE_PI);
  localparam logic signed [ZW-1:0] PH_ROUND  = ZW'(1) <<< (PH_SHIFT - 1);
  localparam logic        [SW-1:0] MAG_ROUND = SW'(1) << (MAG_SHIFT - 1);

  // Stage A registers (a_ready is combinational)
  logic                     a_valid;
  logic                     a_ready;
  logic [LO_W+KW-1:0]       p_lo;
  logic [HI_W+KW-1:0]       p_hi;
  logic signed [OUT_W-1:0]  a_phase;

  logic                     b_ready;
  logic [XFW-1:0]           xf;
  logic signed [ZW-1:0]     z_rnd;
  logic signed [ZW-1:0]     z_q13;
  logic signed [OUT_W-1:0]  phase_next;
  logic [SW-1:0]            sum;
  logic [MW-1:0]            mag_full;
  logic [OUT_W-1:0]         mag_next;

  assign b_ready  = !out_ch.valid || out_ch.ready;
  assign a_ready  = !a_valid || b_ready;
  assign ready_up = a_ready;

  // Stage A: negative x clamps to zero; phase to Q13 with clamp at +-pi
  assign xf    = (x_in > 0) ? x_in[XFW-1:0] : '0;
  assign z_rnd = z_in + PH_ROUND;
  assign z_q13 = z_rnd >>> PH_SHIFT;

  always_comb begin
    if (tag_in.origin) begin
      phase_next = '0;
    end else if (z_q13 > PI_Z) begin
      phase_next = OUT_W'(PHASE_PI);
    end else if (z_q13 < -PI_Z) begin
      phase_next = -OUT_W'(PHASE_PI);
    end else begin
      phase_next = z_q13[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= tag_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && tag_in.valid) begin
      p_lo    <= (LO_W+KW)'(xf[LO_W-1:0]) * (LO_W+KW)'(INV_GAIN);
      p_hi    <= (HI_W+KW)'(xf[XFW-1:LO_W]) * (HI_W+KW)'(INV_GAIN);
      a_phase <= phase_next;
    end
  end

  // Stage B: recombine partial products, round and saturate
  assign sum      = (SW'(p_hi) << LO_W) + SW'(p_lo) + MAG_ROUND;
  assign mag_full = sum[SW-1:MAG_SHIFT];
  assign mag_next = (mag_full > MW'(MAG_MAX)) ? OUT_W'(MAG_MAX) : mag_full[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (b_ready) begin
      out_ch.valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      out_ch.magnitude <= mag_next;
      out_ch.phase     <= a_phase;
    end
  end

endmodule
